// File: sv/clmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clmt_pkg;

    localparam int LIST_DEPTH_DEF = 16;

    localparam int KEY_W  = 32;
    localparam int SVC_W  = 4;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 8;
    localparam int SLOT_W = 4;
    localparam int OCC_W  = 5;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    // one list entry as held in a cell
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SVC_W-1:0]  svc;
        logic [TIME_W-1:0] tm;
        logic [CNT_W-1:0]  cnt;
        logic              valid;
    } t_entry;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic              mode;
        logic              cmp;
        logic              upd;
        logic              hit;
        logic [KEY_W-1:0]  key;
        logic [SVC_W-1:0]  svc;
        logic [TIME_W-1:0] tm;
        logic [CNT_W-1:0]  cnt;
    } t_cell_ctl;

    // rippled down the chain: match seen so far, its count and its slot
    typedef struct packed {
        logic              found;
        logic [CNT_W-1:0]  cnt;
        logic [SLOT_W-1:0] slot;
    } t_link;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? CNT_MAX : c + CNT_ONE;
    endfunction

endpackage

`default_nettype wire

// File: sv/clmt_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface clmt_call_if;
    import clmt_pkg::*;
    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  caller_key;
    logic [SVC_W-1:0]  service_code;
    logic [TIME_W-1:0] call_time;

    modport source (output valid, caller_key, service_code, call_time, input ready);
    modport sink   (input valid, caller_key, service_code, call_time, output ready);
endinterface

interface clmt_result_if;
    import clmt_pkg::*;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot_index;
    logic [CNT_W-1:0]  repeat_count;
    logic              was_hit;
    logic              was_dropped;
    logic [OCC_W-1:0]  occupied;

    modport source (output valid, slot_index, repeat_count, was_hit, was_dropped, occupied,
                    input ready);
    modport sink   (input valid, slot_index, repeat_count, was_hit, was_dropped, occupied,
                    output ready);
endinterface

interface clmt_cfg_if;
    logic valid;
    logic ready;
    logic order_mode;

    modport source (output valid, order_mode, input ready);
    modport sink   (input valid, order_mode, output ready);
endinterface

`default_nettype wire

// File: sv/clmt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module clmt_cell
    import clmt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic              i_head,
    input  wire logic [SLOT_W-1:0] i_pos,
    input  wire t_entry            i_prev,
    input  wire t_link             i_link,
    output t_entry                 o_ent,
    output t_link                  o_link
);

    t_entry r_ent;
    logic   r_match;
    logic   w_write;
    logic   w_shift;
    t_entry w_new;

    always_comb begin
        w_new.key   = i_ctl.key;
        w_new.svc   = i_ctl.svc;
        w_new.tm    = i_ctl.tm;
        w_new.cnt   = i_ctl.cnt;
        w_new.valid = 1'b1;

        if (i_ctl.mode == 1'b0) begin
            // move to front: head takes the call, cells above the hit (or the
            // filled part on a miss) pull their neighbor's entry down
            w_write = i_head;
            w_shift = !i_head && (i_ctl.hit ? !i_link.found : i_prev.valid);
        end else begin
            // queue: the hit slot, or the first empty slot when there is no hit
            w_write = r_match || (!i_ctl.hit && i_prev.valid && !r_ent.valid);
            w_shift = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
            r_match     <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_match <= r_ent.valid && (r_ent.key == i_ctl.key);
            end
            if (i_ctl.upd) begin
                if (w_write) begin
                    r_ent <= w_new;
                end else if (w_shift) begin
                    r_ent <= i_prev;
                end
            end
        end
    end

    // valid keys are unique, so at most one cell matches and OR-ing is a select
    always_comb begin
        o_link.found = i_link.found | r_match;
        o_link.cnt   = i_link.cnt  | (r_match ? r_ent.cnt : '0);
        o_link.slot  = i_link.slot | (r_match ? i_pos : '0);
    end

    assign o_ent = r_ent;

endmodule

`default_nettype wire

// File: sv/call_list_mru_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Call list with repeat counts, held in a chain of LIST_DEPTH entry cells.
// Each call takes three steps: accept, compare (every cell compares its key)
// and update (cells either shift down to their neighbor or load the call);
// the result is held in an output register while the next call is accepted.
// The update step waits while an earlier result is not yet taken. order_mode
// (0 = move to front, 1 = arrival order queue) must be written through the
// config channel only while no call is in flight; the block does not enforce
// it. Valid entries always form a contiguous run from slot 0, tracked by an
// occupancy counter. slot_index and occupied wrap at their field width.
module call_list_mru_table_core
    import clmt_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    clmt_cfg_if.sink     i_cfg,
    clmt_call_if.sink    i_call,
    clmt_result_if.source o_result
);

    localparam int OCNT_W = $clog2(LIST_DEPTH + 1);
    localparam logic [OCNT_W-1:0] OCC_FULL = OCNT_W'(LIST_DEPTH);
    localparam logic [OCNT_W-1:0] OCC_ONE  = OCNT_W'(1);

    t_state            r_state;
    t_state            n_state;
    logic              r_mode;
    logic [KEY_W-1:0]  r_key;
    logic [SVC_W-1:0]  r_svc;
    logic [TIME_W-1:0] r_time;
    logic [OCNT_W-1:0] r_occ;
    logic [OCNT_W-1:0] n_occ;

    logic              r_out_valid;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_hit;
    logic              r_drop;
    logic [OCC_W-1:0]  r_occ_out;

    logic              w_accept;
    logic              w_upd;
    logic              w_full;
    logic              w_hit;
    logic [CNT_W-1:0]  w_new_cnt;
    logic [SLOT_W-1:0] w_slot;
    logic              w_drop;
    t_cell_ctl         w_ctl;

    t_entry w_ent  [LIST_DEPTH];
    t_entry w_prev [LIST_DEPTH];
    t_link  w_link [LIST_DEPTH+1];

    assign i_cfg.ready  = 1'b1;
    assign i_call.ready = (r_state == ST_IDLE);
    assign w_accept     = i_call.valid && i_call.ready;

    always_comb begin
        n_state = r_state;
        w_upd   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (!r_out_valid || o_result.ready) begin
                    w_upd   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_mode <= i_cfg.order_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key  <= i_call.caller_key;
            r_svc  <= i_call.service_code;
            r_time <= i_call.call_time;
        end
    end

    // decision from the end of the chain
    assign w_full    = (r_occ == OCC_FULL);
    assign w_hit     = w_link[LIST_DEPTH].found;
    assign w_new_cnt = w_hit ? sat_inc(w_link[LIST_DEPTH].cnt) : CNT_ONE;
    assign w_drop    = r_mode && !w_hit && w_full;

    always_comb begin
        if (r_mode == 1'b0 || w_drop) begin
            w_slot = '0;
        end else if (w_hit) begin
            w_slot = w_link[LIST_DEPTH].slot;
        end else begin
            w_slot = SLOT_W'(r_occ);
        end
        n_occ = (!w_hit && !w_full) ? r_occ + OCC_ONE : r_occ;
    end

    always_comb begin
        w_ctl.mode = r_mode;
        w_ctl.cmp  = (r_state == ST_CMP);
        w_ctl.upd  = w_upd;
        w_ctl.hit  = w_hit;
        w_ctl.key  = r_key;
        w_ctl.svc  = r_svc;
        w_ctl.tm   = r_time;
        w_ctl.cnt  = w_new_cnt;
    end

    always_comb begin
        w_prev[0]       = '0;
        w_prev[0].valid = 1'b1;
        w_link[0]       = '0;
    end

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        if (g > 0) begin : g_prev
            assign w_prev[g] = w_ent[g-1];
        end
        clmt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_head  (g == 0),
            .i_pos   (SLOT_W'(g)),
            .i_prev  (w_prev[g]),
            .i_link  (w_link[g]),
            .o_ent   (w_ent[g]),
            .o_link  (w_link[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_upd) begin
                r_occ       <= n_occ;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_slot    <= w_slot;
            r_cnt     <= w_drop ? '0 : w_new_cnt;
            r_hit     <= w_hit;
            r_drop    <= w_drop;
            r_occ_out <= OCC_W'(n_occ);
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.slot_index   = r_slot;
    assign o_result.repeat_count = r_cnt;
    assign o_result.was_hit      = r_hit;
    assign o_result.was_dropped  = r_drop;
    assign o_result.occupied     = r_occ_out;

endmodule

`default_nettype wire

// File: sv/clmt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module clmt_checker
    import clmt_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [SLOT_W-1:0] i_slot,
    input wire logic [CNT_W-1:0]  i_cnt,
    input wire logic              i_hit,
    input wire logic              i_drop,
    input wire logic [OCC_W-1:0]  i_occ
);

    // one call in flight: the block is busy right after taking a call
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("call accepted while previous call in flight");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_slot) && $stable(i_cnt) && $stable(i_hit)
             && $stable(i_drop) && $stable(i_occ)))
        else $error("stalled result changed");

    a_drop_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_drop) |-> (i_cnt == '0 && i_slot == '0 && !i_hit))
        else $error("dropped call with nonzero fields");

    a_stored_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_drop) |-> (i_cnt != '0 && i_occ != '0))
        else $error("stored call with zero count or empty list");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind call_list_mru_table_core clmt_checker u_clmt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_call.valid),
    .i_in_ready  (i_call.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_slot      (o_result.slot_index),
    .i_cnt       (o_result.repeat_count),
    .i_hit       (o_result.was_hit),
    .i_drop      (o_result.was_dropped),
    .i_occ       (o_result.occupied)
);

`default_nettype wire

// File: bench/tb_call_list_mru_table_core.sv
`timescale 1ns / 1ps

module tb_call_list_mru_table_core;
    import clmt_pkg::*;

    localparam int DEPTH       = LIST_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_CALLS = 1600;
    localparam int HAMMER_CALLS = 270;
    localparam int LONG_HOLD   = 400;

    localparam logic MODE_MRU   = 1'b0;
    localparam logic MODE_QUEUE = 1'b1;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
        logic              hit;
        logic              dropped;
        logic [OCC_W-1:0]  occ;
    } t_call_outcome;

    // Mirror of the call list; predicts one outcome per accepted call.
    class call_log_scoreboard;
        logic               order_mode;
        logic [KEY_W-1:0]   keys [DEPTH];
        logic [SVC_W-1:0]   svcs [DEPTH];
        logic [TIME_W-1:0]  stamps [DEPTH];
        logic [CNT_W-1:0]   counts [DEPTH];
        logic               used [DEPTH];
        t_call_outcome      pending_outcomes[$];
        int errors;
        int checked;
        int hits;
        int drops;
        int saturated;

        function new();
            order_mode = MODE_MRU;
            for (int i = 0; i < DEPTH; i++) begin
                keys[i] = '0;
                svcs[i] = '0;
                stamps[i] = '0;
                counts[i] = '0;
                used[i] = 1'b0;
            end
            errors = 0;
            checked = 0;
            hits = 0;
            drops = 0;
            saturated = 0;
        endfunction

        function void shift_down(int upto);
            for (int i = upto; i > 0; i--) begin
                keys[i] = keys[i-1];
                svcs[i] = svcs[i-1];
                stamps[i] = stamps[i-1];
                counts[i] = counts[i-1];
                used[i] = used[i-1];
            end
        endfunction

        function void note_call(logic [KEY_W-1:0] key, logic [SVC_W-1:0] svc,
                                logic [TIME_W-1:0] tm);
            t_call_outcome o;
            int pos;
            int n;
            logic [CNT_W-1:0] c;
            o = '0;
            pos = -1;
            c = '0;
            if (order_mode == MODE_MRU) begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (used[i] && keys[i] == key) begin
                        pos = i;
                        break;
                    end
                end
                if (pos >= 0) begin
                    c = (counts[pos] == 8'hFF) ? counts[pos] : counts[pos] + 8'd1;
                    o.hit = 1'b1;
                    shift_down(pos);
                end else begin
                    // shift stops at the first hole; full list loses its tail
                    pos = DEPTH - 1;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (!used[i]) begin
                            pos = i;
                            break;
                        end
                    end
                    shift_down(pos);
                    c = 8'd1;
                end
                pos = 0;
            end else begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (!used[i]) begin
                        pos = i;
                        c = 8'd1;
                        break;
                    end
                    if (keys[i] == key) begin
                        pos = i;
                        c = (counts[i] == 8'hFF) ? counts[i] : counts[i] + 8'd1;
                        o.hit = 1'b1;
                        break;
                    end
                end
            end
            if (pos >= 0) begin
                keys[pos] = key;
                svcs[pos] = svc;
                stamps[pos] = tm;
                counts[pos] = c;
                used[pos] = 1'b1;
                o.slot = SLOT_W'(pos);
            end else begin
                o.dropped = 1'b1;
                o.slot = '0;
                c = '0;
            end
            o.count = c;
            n = 0;
            for (int i = 0; i < DEPTH; i++)
                if (used[i])
                    n++;
            o.occ = OCC_W'(n);
            if (o.hit)
                hits++;
            if (o.dropped)
                drops++;
            if (o.hit && c == 8'hFF)
                saturated++;
            pending_outcomes.push_back(o);
        endfunction

        function void check_result(t_call_outcome got);
            t_call_outcome want;
            if (pending_outcomes.size() == 0) begin
                $error("result with no call outstanding");
                errors++;
                return;
            end
            want = pending_outcomes.pop_front();
            checked++;
            if (got.slot !== want.slot) begin
                $error("slot_index expected %0d actual %0d", want.slot, got.slot);
                errors++;
            end
            if (got.count !== want.count) begin
                $error("repeat_count expected %0d actual %0d", want.count, got.count);
                errors++;
            end
            if (got.hit !== want.hit) begin
                $error("was_hit expected %0d actual %0d", want.hit, got.hit);
                errors++;
            end
            if (got.dropped !== want.dropped) begin
                $error("was_dropped expected %0d actual %0d", want.dropped, got.dropped);
                errors++;
            end
            if (got.occ !== want.occ) begin
                $error("occupied expected %0d actual %0d", want.occ, got.occ);
                errors++;
            end
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction

        function logic [KEY_W-1:0] key_at(int i);
            return keys[i];
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    clmt_cfg_if    cfg_bus();
    clmt_call_if   call_bus();
    clmt_result_if result_bus();

    call_list_mru_table_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_call   (call_bus),
        .o_result (result_bus)
    );

    call_log_scoreboard tracker = new();

    int cycles;
    int calls_sent;
    int burst_left;
    int mode_writes;
    bit hold_request;
    logic [KEY_W-1:0] key_pool [32];
    int pool_n;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, tracker.pending());
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: changing stall pattern, plus one long hold on request
    initial begin
        int pattern;
        int pattern_left;
        int hold_left;
        int tick;
        result_bus.ready = 1'b0;
        pattern = 0;
        pattern_left = 0;
        hold_left = 0;
        tick = 0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_request) begin
                hold_left = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (pattern_left == 0) begin
                pattern = $urandom_range(0, 3);
                pattern_left = $urandom_range(20, 200);
            end
            pattern_left--;
            if (hold_left > 0) begin
                hold_left--;
                result_bus.ready = 1'b0;
            end else begin
                case (pattern)
                    0: result_bus.ready = 1'b1;
                    1: result_bus.ready = 1'($urandom_range(0, 1));
                    2: result_bus.ready = ($urandom_range(0, 9) == 0);
                    default: result_bus.ready = (tick % 4 != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_bus.valid && result_bus.ready)
            tracker.check_result({result_bus.slot_index, result_bus.repeat_count,
                                  result_bus.was_hit, result_bus.was_dropped,
                                  result_bus.occupied});
    end

    task automatic send_call(input logic [KEY_W-1:0] key, input logic [SVC_W-1:0] svc,
                             input logic [TIME_W-1:0] tm);
        int gap;
        int r;
        if (burst_left == 0) begin
            r = $urandom_range(0, 9);
            if (r < 3)
                gap = 0;
            else if (r < 9)
                gap = $urandom_range(1, 6);
            else
                gap = $urandom_range(15, 30);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                @(negedge i_clk);
                call_bus.valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        call_bus.valid = 1'b1;
        call_bus.caller_key = key;
        call_bus.service_code = svc;
        call_bus.call_time = tm;
        @(posedge i_clk);
        while (!call_bus.ready)
            @(posedge i_clk);
        tracker.note_call(key, svc, tm);
        burst_left--;
        calls_sent++;
    endtask

    // stop offering calls and let every outstanding result drain
    task automatic drain_calls();
        @(negedge i_clk);
        call_bus.valid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_mode(input logic m);
        drain_calls();
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.order_mode = m;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        tracker.order_mode = m;
        mode_writes++;
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return tracker.key_at($urandom_range(0, DEPTH - 1));
        else if (r < 80)
            return key_pool[$urandom_range(0, pool_n - 1)];
        else if (r < 93)
            return $urandom;
        else if (r < 96)
            return '0;
        else
            return '1;
    endfunction

    initial begin
        int phase;
        int len;
        int random_sent;
        logic [KEY_W-1:0] hammer_key;
        i_rst_n = 1'b0;
        call_bus.valid = 1'b0;
        call_bus.caller_key = '0;
        call_bus.service_code = '0;
        call_bus.call_time = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.order_mode = MODE_MRU;
        calls_sent = 0;
        burst_left = 0;
        mode_writes = 0;
        hold_request = 1'b0;
        pool_n = 4;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // queue mode on an empty list: holes get filled, key zero never
        // matches a cleared slot
        write_mode(MODE_QUEUE);
        send_call(32'h0000_0000, 4'h0, 32'h0000_0000);
        send_call(32'h0000_0000, 4'hF, 32'hFFFF_FFFF);
        send_call(32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF);
        send_call(32'h0000_0001, 4'h5, 32'h0000_0001);
        send_call(32'hFFFF_FFFF, 4'hA, 32'h8000_0000);

        // move to front: hit from the middle, miss that stops at the hole,
        // then fill the list and push the tail out
        write_mode(MODE_MRU);
        send_call(32'h0000_0001, 4'h3, 32'h0000_0002);
        send_call(32'hA5A5_A5A5, 4'hC, 32'h5A5A_5A5A);
        send_call(32'h0000_0000, 4'h1, 32'h0000_0003);
        for (int i = 0; i < 13; i++)
            send_call(32'h0000_0100 + i, 4'(i), 32'h0000_1000 + i);

        // full queue: a stranger is dropped, a known caller is updated in place
        write_mode(MODE_QUEUE);
        send_call(32'h5555_5555, 4'h9, 32'h7FFF_FFFF);
        send_call(32'h0000_010C, 4'h6, 32'h1234_5678);

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_CALLS) begin
            if (phase % 3 == 2)
                write_mode(1'($urandom_range(0, 1)));
            else
                write_mode(phase[0]);
            case ($urandom_range(0, 3))
                0: pool_n = 4;
                1: pool_n = 15;
                2: pool_n = 17;
                default: pool_n = 32;
            endcase
            for (int i = 0; i < 32; i++)
                key_pool[i] = $urandom;
            if (phase == 1)
                hold_request = 1'b1;
            if (phase == 4) begin
                // drive one caller past the count ceiling
                hammer_key = $urandom;
                for (int n = 0; n < HAMMER_CALLS; n++) begin
                    send_call(hammer_key, 4'($urandom), $urandom);
                    random_sent++;
                end
            end else begin
                len = $urandom_range(80, 160);
                for (int n = 0; n < len; n++) begin
                    if (phase == 3 && n == len / 2)
                        drain_calls();
                    send_call(pick_key(), 4'($urandom), $urandom);
                    random_sent++;
                end
            end
            phase++;
        end

        drain_calls();
        repeat (20) @(posedge i_clk);
        $display("%0d calls over %0d phases, %0d mode writes; %0d results checked",
                 calls_sent, phase, mode_writes, tracker.checked);
        $display("hits %0d, drops %0d, saturated counts %0d, errors %0d",
                 tracker.hits, tracker.drops, tracker.saturated, tracker.errors);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
